// File: hdl/i2cms_pkg.sv
// Shared types and constants for the I2C master byte sequencer.
// No dependencies; imported by i2cms_step and i2c_master_byte_sequencer_top.
package i2cms_pkg;

    // Command codes, same encoding as the func field of an input item
    typedef enum logic [2:0] {
        CMD_IDLE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_PUT   = 3'd3,
        CMD_GET   = 3'd4,
        CMD_ADDR  = 3'd5
    } cmd_t;

    // Phases of the acknowledge tail after a sent byte
    localparam logic [2:0] PH_ACK_SETUP   = 3'd0;
    localparam logic [2:0] PH_ACK_SCL     = 3'd1;
    localparam logic [2:0] PH_ACK_RELEASE = 3'd2;
    localparam logic [2:0] PH_ACK_POLL    = 3'd3;
    localparam logic [2:0] PH_ACK_END     = 3'd4;

    // Phases inside one bit slot (SCL low, high, low), and the last phase of a start or stop condition
    localparam logic [2:0] PH_BIT_HIGH     = 3'd1;
    localparam logic [2:0] PHASES_PER_BIT  = 3'd3;
    localparam logic [2:0] PH_COND_LAST    = 3'd2;

    localparam logic [7:0] ADDR_10BIT_MASK   = 8'hF8;
    localparam logic [7:0] ADDR_10BIT_PREFIX = 8'hF0;
    localparam logic [7:0] GCALL_MASK        = 8'hFE;
    localparam logic [7:0] GCALL_CODE        = 8'h00;

    localparam logic [3:0] ACK_POLL_RESET = 4'd10;
    localparam logic [3:0] POLL_COUNT_MAX = 4'd15;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  tx_byte;
        logic [15:0] target_address;
        logic        last_read;
        logic        sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_seen;
        logic       cmd_rejected;
    } out_item_t;

    // Sequencer state carried from one phase to the next
    typedef struct packed {
        cmd_t       active_command;
        logic [2:0] phase_step;
        logic [3:0] bit_index;
        logic [7:0] send_shift;
        logic [7:0] receive_shift;
        logic [8:0] pending_high_byte;
        logic [3:0] poll_count;
        logic       nak_flag;
        logic       ack_flag;
        logic       scl;
        logic       sda;
        logic       drv;
    } seq_state_t;

endpackage

// File: hdl/i2cms_step.sv
// One bus phase of the sequencer: next state and result from current state and item.
// Depends on i2cms_pkg.
module i2cms_step
    import i2cms_pkg::*;
(
    input  seq_state_t cur,
    input  in_item_t   item,
    input  logic [3:0] ack_poll_limit,
    output seq_state_t nxt,
    output out_item_t  res
);

    logic       is_cmd;
    logic       rejected;
    logic       done;
    logic [3:0] limit;
    logic [7:0] lo;
    logic       bit_val;

    always_comb
    begin
        nxt      = cur;
        rejected = 1'b0;
        done     = 1'b0;
        is_cmd   = (item.func >= CMD_START) && (item.func <= CMD_ADDR);
        limit    = (ack_poll_limit == 4'd0) ? 4'd1 : ack_poll_limit;
        lo       = item.target_address[7:0];
        bit_val  = 1'b0;

        // Start a new command, or flag one that arrives while busy
        if (cur.active_command == CMD_IDLE && is_cmd)
        begin
            nxt.active_command = cmd_t'(item.func);
            nxt.phase_step     = 3'd0;
            nxt.bit_index      = 4'd0;
            case (cmd_t'(item.func))
                CMD_PUT:
                begin
                    nxt.send_shift = item.tx_byte;
                    nxt.poll_count = 4'd0;
                    nxt.ack_flag   = 1'b0;
                end
                CMD_GET:
                begin
                    nxt.receive_shift = 8'd0;
                    nxt.nak_flag      = item.last_read;
                end
                CMD_ADDR:
                begin
                    nxt.send_shift = lo;
                    nxt.poll_count = 4'd0;
                    nxt.ack_flag   = 1'b0;
                    if ((lo & ADDR_10BIT_MASK) == ADDR_10BIT_PREFIX
                        || (lo & GCALL_MASK) == GCALL_CODE)
                        nxt.pending_high_byte = {1'b1, item.target_address[15:8]};
                    else
                        nxt.pending_high_byte = 9'd0;
                end
                default:
                begin
                end
            endcase
        end
        else if (cur.active_command != CMD_IDLE && is_cmd)
        begin
            rejected = 1'b1;
        end

        // Produce the pin levels of this phase and advance the sequence
        case (nxt.active_command)
            CMD_START, CMD_ADDR:
            begin
                if (nxt.phase_step == 3'd0)
                begin
                    {nxt.scl, nxt.sda, nxt.drv} = 3'b111;
                    nxt.phase_step = 3'd1;
                end
                else if (nxt.phase_step == 3'd1)
                begin
                    {nxt.scl, nxt.sda, nxt.drv} = 3'b101;
                    nxt.phase_step = PH_COND_LAST;
                end
                else
                begin
                    {nxt.scl, nxt.sda, nxt.drv} = 3'b001;
                    nxt.phase_step = 3'd0;
                    if (nxt.active_command == CMD_ADDR)
                    begin
                        nxt.active_command = CMD_PUT;
                        nxt.bit_index      = 4'd0;
                    end
                    else
                    begin
                        nxt.active_command = CMD_IDLE;
                        done = 1'b1;
                    end
                end
            end
            CMD_STOP:
            begin
                if (nxt.phase_step == 3'd0)
                begin
                    {nxt.scl, nxt.sda, nxt.drv} = 3'b001;
                    nxt.phase_step = 3'd1;
                end
                else if (nxt.phase_step == 3'd1)
                begin
                    {nxt.scl, nxt.sda, nxt.drv} = 3'b101;
                    nxt.phase_step = PH_COND_LAST;
                end
                else
                begin
                    {nxt.scl, nxt.sda, nxt.drv} = 3'b111;
                    nxt.phase_step     = 3'd0;
                    nxt.active_command = CMD_IDLE;
                    done = 1'b1;
                end
            end
            CMD_PUT:
            begin
                if (!nxt.bit_index[3])
                begin
                    // Data bit, MSB first
                    bit_val = nxt.send_shift[3'd7 - nxt.bit_index[2:0]];
                    {nxt.scl, nxt.sda, nxt.drv} =
                        {nxt.phase_step == PH_BIT_HIGH, bit_val, 1'b1};
                    nxt.phase_step = nxt.phase_step + 3'd1;
                    if (nxt.phase_step >= PHASES_PER_BIT)
                    begin
                        nxt.phase_step = 3'd0;
                        nxt.bit_index  = nxt.bit_index + 4'd1;
                    end
                end
                else if (nxt.phase_step == PH_ACK_SETUP)
                begin
                    {nxt.scl, nxt.sda, nxt.drv} = 3'b011;
                    nxt.phase_step = PH_ACK_SCL;
                end
                else if (nxt.phase_step == PH_ACK_SCL)
                begin
                    {nxt.scl, nxt.sda, nxt.drv} = 3'b111;
                    nxt.phase_step = PH_ACK_RELEASE;
                end
                else if (nxt.phase_step == PH_ACK_RELEASE)
                begin
                    {nxt.scl, nxt.sda, nxt.drv} = 3'b110;
                    nxt.phase_step = PH_ACK_POLL;
                end
                else if (nxt.phase_step == PH_ACK_POLL)
                begin
                    // Poll for acknowledge, give up at the limit
                    {nxt.scl, nxt.sda, nxt.drv} = 3'b110;
                    if (nxt.poll_count < POLL_COUNT_MAX)
                        nxt.poll_count = nxt.poll_count + 4'd1;
                    if (!item.sda_in)
                    begin
                        nxt.ack_flag   = 1'b1;
                        nxt.phase_step = PH_ACK_END;
                    end
                    else if (nxt.poll_count >= limit)
                    begin
                        nxt.phase_step = PH_ACK_END;
                    end
                end
                else
                begin
                    {nxt.scl, nxt.sda, nxt.drv} = 3'b011;
                    if (nxt.pending_high_byte[8])
                    begin
                        // Chain the high address byte
                        nxt.send_shift        = nxt.pending_high_byte[7:0];
                        nxt.bit_index         = 4'd0;
                        nxt.phase_step        = 3'd0;
                        nxt.poll_count        = 4'd0;
                        nxt.ack_flag          = 1'b0;
                        nxt.pending_high_byte = 9'd0;
                    end
                    else
                    begin
                        nxt.phase_step     = 3'd0;
                        nxt.bit_index      = 4'd0;
                        nxt.active_command = CMD_IDLE;
                        done = 1'b1;
                    end
                end
            end
            CMD_GET:
            begin
                if (!nxt.bit_index[3])
                begin
                    // Sample on SCL high, SDA released
                    if (nxt.phase_step == PH_BIT_HIGH)
                    begin
                        {nxt.scl, nxt.sda, nxt.drv} = 3'b110;
                        nxt.receive_shift = {nxt.receive_shift[6:0], item.sda_in};
                    end
                    else
                    begin
                        {nxt.scl, nxt.sda, nxt.drv} = 3'b010;
                    end
                    nxt.phase_step = nxt.phase_step + 3'd1;
                    if (nxt.phase_step >= PHASES_PER_BIT)
                    begin
                        nxt.phase_step = 3'd0;
                        nxt.bit_index  = nxt.bit_index + 4'd1;
                    end
                end
                else
                begin
                    // Clock out ACK or NAK
                    {nxt.scl, nxt.sda, nxt.drv} =
                        {nxt.phase_step == PH_BIT_HIGH, nxt.nak_flag, 1'b1};
                    nxt.phase_step = nxt.phase_step + 3'd1;
                    if (nxt.phase_step >= PHASES_PER_BIT)
                    begin
                        nxt.phase_step     = 3'd0;
                        nxt.bit_index      = 4'd0;
                        nxt.active_command = CMD_IDLE;
                        done = 1'b1;
                    end
                end
            end
            default:
            begin
                // Idle: pins hold the last levels
                nxt.active_command = CMD_IDLE;
                nxt.phase_step     = 3'd0;
                nxt.bit_index      = 4'd0;
            end
        endcase

        res.scl          = nxt.scl;
        res.sda_out      = nxt.sda | ~nxt.drv;
        res.sda_drive    = nxt.drv;
        res.busy_res     = (nxt.active_command != CMD_IDLE);
        res.done_res     = done;
        res.rx_byte      = nxt.receive_shift;
        res.ack_seen     = nxt.ack_flag;
        res.cmd_rejected = rejected;
    end

endmodule

// File: hdl/i2c_master_byte_sequencer_top.sv
// Top level of the I2C master byte sequencer: handshakes, input and result registers.
// Depends on i2cms_pkg and i2cms_step.
//
// Usage:
//   in_valid/in_ready/in_item carry one bus phase tick per transfer: the
//   sampled SDA level and an optional command (start, stop, put byte,
//   get byte, address). out_valid/out_ready/out_item return the pin levels
//   and status for that phase, exactly one result per input transfer.
//   cfg_valid/cfg_ready/cfg_data write ack_poll_limit; always ready, write
//   it only while no phase is in flight.
// Path: an input transfer loads the input register; the phase logic then
//   passes it into the result register on an edge where the pipeline
//   advances (result register free or being taken).
// Throughput: one phase per cycle while out_ready is high; the sequencer
//   state register closes its loop through the phase logic.
// Reset: idle, pins SCL high, SDA high and driven, ack_poll_limit 10, both
//   pipeline registers empty.
// Stall: when out_ready is low the result holds; the input register still
//   takes one more transfer, then in_ready drops until the result is taken.
module i2c_master_byte_sequencer_top
    import i2cms_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [3:0] cfg_data
);

    logic       in_valid_reg;
    in_item_t   in_item_reg;
    logic       out_valid_reg;
    out_item_t  out_item_reg;
    seq_state_t state_reg;
    seq_state_t state_next;
    out_item_t  res_next;
    logic [3:0] ack_poll_limit_reg;
    logic       advance;

    // Phase logic
    i2cms_step u_step (
        .cur            (state_reg),
        .item           (in_item_reg),
        .ack_poll_limit (ack_poll_limit_reg),
        .nxt            (state_next),
        .res            (res_next)
    );

    // Move the pipeline when the result register is free or being taken
    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign cfg_ready = 1'b1;

    // Control and sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            ack_poll_limit_reg <= ACK_POLL_RESET;
            state_reg          <= '{
                active_command:    CMD_IDLE,
                phase_step:        3'd0,
                bit_index:         4'd0,
                send_shift:        8'd0,
                receive_shift:     8'd0,
                pending_high_byte: 9'd0,
                poll_count:        4'd0,
                nak_flag:          1'b0,
                ack_flag:          1'b0,
                scl:               1'b1,
                sda:               1'b1,
                drv:               1'b1
            };
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
            if (advance && in_valid_reg)
                state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                ack_poll_limit_reg <= cfg_data;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_item_reg <= in_item;
        if (advance && in_valid_reg)
            out_item_reg <= res_next;
    end

    // A phase that ends a command never reports busy
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.done_res |-> !out_item_reg.busy_res)
        else $error("done and busy in one phase");

    // Released SDA reads back as high
    a_release_high: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_item_reg.sda_drive |-> out_item_reg.sda_out)
        else $error("sda_out low while released");

    // A command is never rejected while the sequencer is idle
    a_no_reject_idle: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_valid_reg && state_reg.active_command == CMD_IDLE
        |=> !out_item_reg.cmd_rejected)
        else $error("command rejected while idle");

    // Busy in a result matches the state left behind
    a_busy_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_valid_reg
        |=> out_item_reg.busy_res == (state_reg.active_command != CMD_IDLE))
        else $error("busy flag out of step with state");

endmodule
